/* rtl/core/cbdppu_pkg.sv */
// Shared types, constants and address map of the picture processor register port.
`timescale 1ns / 1ps

package cbdppu_pkg;

    // Memory sizes and the address widths that follow from them
    localparam int RAM_BYTES  = 2048;
    localparam int ROM_BYTES  = 32768;
    localparam int VRAM_BYTES = 16384;
    localparam int OAM_BYTES  = 256;

    localparam int RAM_AW  = $clog2(RAM_BYTES);
    localparam int ROM_AW  = $clog2(ROM_BYTES);
    localparam int VRAM_AW = $clog2(VRAM_BYTES);
    localparam int OAM_AW  = $clog2(OAM_BYTES);

    // Stream word widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    // Register addresses on the CPU bus
    localparam logic [15:0] ADDR_CTRL     = 16'h2000;
    localparam logic [15:0] ADDR_MASK     = 16'h2001;
    localparam logic [15:0] ADDR_STATUS   = 16'h2002;
    localparam logic [15:0] ADDR_OAM_ADDR = 16'h2003;
    localparam logic [15:0] ADDR_OAM_DATA = 16'h2004;
    localparam logic [15:0] ADDR_SCROLL   = 16'h2005;
    localparam logic [15:0] ADDR_VADDR    = 16'h2006;
    localparam logic [15:0] ADDR_VDATA    = 16'h2007;

    // Bus access kind; the fourth code does nothing
    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_LOAD  = 2'd2
    } func_t;

    // Where the read byte comes from
    typedef enum logic [2:0] {
        SRC_ZERO,
        SRC_STATUS,
        SRC_RAM,
        SRC_ROM,
        SRC_OAM,
        SRC_VRAM
    } rd_src_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        vblank_flag;
        logic        sprite_zero_hit;
        logic        sprite_overflow_flag;
    } item_t;

    // Register values presented with every result
    typedef struct packed {
        logic [7:0]  control;
        logic [1:0]  mask;     // bit 0 background, bit 1 sprites
        logic [15:0] scroll;   // low byte x, high byte y
    } view_t;

    // Memory port commands from the decoder
    typedef struct packed {
        logic               ram_we;
        logic               rom_we;
        logic               oam_we;
        logic               vram_we;
        logic [RAM_AW-1:0]  ram_addr;
        logic [ROM_AW-1:0]  rom_addr;
        logic [OAM_AW-1:0]  oam_addr;
        logic [VRAM_AW-1:0] vram_addr;
        logic [7:0]         wdata;
    } mem_cmd_t;

    // Read selection handed to the result stage
    typedef struct packed {
        rd_src_t    src;
        logic [7:0] status;
    } rd_sel_t;

endpackage

/* rtl/core/cbdppu_regs.sv */
// Address decode and picture-unit register state; issues memory commands.
`timescale 1ns / 1ps

module cbdppu_regs (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fire,      // item in the decode stage commits this cycle
    input  cbdppu_pkg::item_t     item,
    output cbdppu_pkg::mem_cmd_t  mem_cmd,
    output cbdppu_pkg::rd_sel_t   rd_sel,
    output cbdppu_pkg::view_t     view_next
);

    logic [cbdppu_pkg::OAM_AW-1:0]  oam_ptr_reg, oam_ptr_next;
    logic [cbdppu_pkg::VRAM_AW-1:0] vptr_reg, vptr_next;
    logic [7:0]                     latch_reg, latch_next;
    logic                           first_reg, first_next;
    logic [7:0]                     ctrl_reg, ctrl_next;
    logic [1:0]                     mask_reg, mask_next;
    logic [15:0]                    scroll_reg, scroll_next;

    logic [cbdppu_pkg::VRAM_AW-1:0] vstep;
    logic                           is_ram;
    logic                           is_rom;
    logic                           ram_we, rom_we, oam_we, vram_we;

    assign vstep  = ctrl_reg[2] ? cbdppu_pkg::VRAM_AW'(32) : cbdppu_pkg::VRAM_AW'(1);
    assign is_ram = (item.address[15:13] == 3'd0);
    assign is_rom = item.address[15];

    always_comb begin
        oam_ptr_next = oam_ptr_reg;
        vptr_next    = vptr_reg;
        latch_next   = latch_reg;
        first_next   = first_reg;
        ctrl_next    = ctrl_reg;
        mask_next    = mask_reg;
        scroll_next  = scroll_reg;
        ram_we       = 1'b0;
        rom_we       = 1'b0;
        oam_we       = 1'b0;
        vram_we      = 1'b0;
        rd_sel.src   = cbdppu_pkg::SRC_ZERO;
        rd_sel.status = {item.vblank_flag, item.sprite_zero_hit,
                         item.sprite_overflow_flag, 5'd0};

        case (item.func)
            cbdppu_pkg::FUNC_READ: begin
                if (is_ram) begin
                    rd_sel.src = cbdppu_pkg::SRC_RAM;
                end else if (is_rom) begin
                    rd_sel.src = cbdppu_pkg::SRC_ROM;
                end else begin
                    case (item.address)
                        cbdppu_pkg::ADDR_STATUS: begin
                            rd_sel.src = cbdppu_pkg::SRC_STATUS;
                            first_next = 1'b1;
                        end
                        cbdppu_pkg::ADDR_OAM_DATA: begin
                            rd_sel.src = cbdppu_pkg::SRC_OAM;
                        end
                        cbdppu_pkg::ADDR_VDATA: begin
                            rd_sel.src = cbdppu_pkg::SRC_VRAM;
                            vptr_next  = vptr_reg + vstep;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            cbdppu_pkg::FUNC_WRITE: begin
                if (is_ram) begin
                    ram_we = 1'b1;
                end else begin
                    case (item.address)
                        cbdppu_pkg::ADDR_CTRL: begin
                            ctrl_next = item.write_data;
                        end
                        cbdppu_pkg::ADDR_MASK: begin
                            mask_next = {item.write_data[4], item.write_data[3]};
                        end
                        cbdppu_pkg::ADDR_OAM_ADDR: begin
                            oam_ptr_next = item.write_data;
                        end
                        cbdppu_pkg::ADDR_OAM_DATA: begin
                            oam_we       = 1'b1;
                            oam_ptr_next = oam_ptr_reg + cbdppu_pkg::OAM_AW'(1);
                        end
                        cbdppu_pkg::ADDR_SCROLL: begin
                            if (first_reg) begin
                                scroll_next[7:0] = item.write_data;
                            end else begin
                                scroll_next[15:8] = item.write_data;
                            end
                            first_next = ~first_reg;
                        end
                        cbdppu_pkg::ADDR_VADDR: begin
                            if (first_reg) begin
                                latch_next = item.write_data;
                            end else begin
                                vptr_next = cbdppu_pkg::VRAM_AW'({latch_reg[5:0],
                                                                 item.write_data});
                            end
                            first_next = ~first_reg;
                        end
                        cbdppu_pkg::ADDR_VDATA: begin
                            vram_we   = 1'b1;
                            vptr_next = vptr_reg + vstep;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            cbdppu_pkg::FUNC_LOAD: begin
                rom_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Memory addresses use the pointers as they stand before this access
    always_comb begin
        mem_cmd.ram_we    = fire & ram_we;
        mem_cmd.rom_we    = fire & rom_we;
        mem_cmd.oam_we    = fire & oam_we;
        mem_cmd.vram_we   = fire & vram_we;
        mem_cmd.ram_addr  = item.address[cbdppu_pkg::RAM_AW-1:0];
        mem_cmd.rom_addr  = item.address[cbdppu_pkg::ROM_AW-1:0];
        mem_cmd.oam_addr  = oam_ptr_reg;
        mem_cmd.vram_addr = vptr_reg;
        mem_cmd.wdata     = item.write_data;
    end

    assign view_next.control = fire ? ctrl_next   : ctrl_reg;
    assign view_next.mask    = fire ? mask_next   : mask_reg;
    assign view_next.scroll  = fire ? scroll_next : scroll_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oam_ptr_reg <= '0;
            vptr_reg    <= '0;
            latch_reg   <= '0;
            first_reg   <= 1'b1;
            ctrl_reg    <= '0;
            mask_reg    <= '0;
            scroll_reg  <= '0;
        end else if (fire) begin
            oam_ptr_reg <= oam_ptr_next;
            vptr_reg    <= vptr_next;
            latch_reg   <= latch_next;
            first_reg   <= first_next;
            ctrl_reg    <= ctrl_next;
            mask_reg    <= mask_next;
            scroll_reg  <= scroll_next;
        end
    end

endmodule

/* rtl/core/cbdppu_mem.sv */
// Work RAM, program ROM, sprite memory and video memory with registered reads.
`timescale 1ns / 1ps

module cbdppu_mem (
    input  logic                 aclk,
    input  logic                 rd_en,
    input  cbdppu_pkg::mem_cmd_t mem_cmd,
    output logic [7:0]           ram_rdata,
    output logic [7:0]           rom_rdata,
    output logic [7:0]           oam_rdata,
    output logic [7:0]           vram_rdata
);

    logic [7:0] ram_mem  [cbdppu_pkg::RAM_BYTES];
    logic [7:0] rom_mem  [cbdppu_pkg::ROM_BYTES];
    logic [7:0] oam_mem  [cbdppu_pkg::OAM_BYTES];
    logic [7:0] vram_mem [cbdppu_pkg::VRAM_BYTES];

    always_ff @(posedge aclk) begin
        if (mem_cmd.ram_we) begin
            ram_mem[mem_cmd.ram_addr] <= mem_cmd.wdata;
        end
        if (rd_en) begin
            ram_rdata <= ram_mem[mem_cmd.ram_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_cmd.rom_we) begin
            rom_mem[mem_cmd.rom_addr] <= mem_cmd.wdata;
        end
        if (rd_en) begin
            rom_rdata <= rom_mem[mem_cmd.rom_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_cmd.oam_we) begin
            oam_mem[mem_cmd.oam_addr] <= mem_cmd.wdata;
        end
        if (rd_en) begin
            oam_rdata <= oam_mem[mem_cmd.oam_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_cmd.vram_we) begin
            vram_mem[mem_cmd.vram_addr] <= mem_cmd.wdata;
        end
        if (rd_en) begin
            vram_rdata <= vram_mem[mem_cmd.vram_addr];
        end
    end

endmodule

/* rtl/core/cbdppu_out.sv */
// Read byte selection and result word register.
`timescale 1ns / 1ps

module cbdppu_out (
    input  logic                                aclk,
    input  logic                                adv,
    input  cbdppu_pkg::rd_sel_t                 rd_sel,
    input  cbdppu_pkg::view_t                   view_next,
    input  logic [7:0]                          ram_rdata,
    input  logic [7:0]                          rom_rdata,
    input  logic [7:0]                          oam_rdata,
    input  logic [7:0]                          vram_rdata,
    output logic [cbdppu_pkg::M_TDATA_W-1:0]    m_word
);

    cbdppu_pkg::rd_sel_t sel_reg;
    cbdppu_pkg::view_t   view_mid_reg;
    cbdppu_pkg::view_t   view_out_reg;
    logic [7:0]          rdata_reg;
    logic [7:0]          rdata_next;

    always_comb begin
        case (sel_reg.src)
            cbdppu_pkg::SRC_STATUS: rdata_next = sel_reg.status;
            cbdppu_pkg::SRC_RAM:    rdata_next = ram_rdata;
            cbdppu_pkg::SRC_ROM:    rdata_next = rom_rdata;
            cbdppu_pkg::SRC_OAM:    rdata_next = oam_rdata;
            cbdppu_pkg::SRC_VRAM:   rdata_next = vram_rdata;
            default:                rdata_next = 8'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sel_reg      <= rd_sel;
            view_mid_reg <= view_next;
            rdata_reg    <= rdata_next;
            view_out_reg <= view_mid_reg;
        end
    end

    assign m_word = {6'd0,
                     view_out_reg.scroll[15:8],
                     view_out_reg.scroll[7:0],
                     view_out_reg.mask[1],
                     view_out_reg.mask[0],
                     view_out_reg.control[2],
                     view_out_reg.control[1:0],
                     view_out_reg.control[3],
                     view_out_reg.control[4],
                     view_out_reg.control[5],
                     view_out_reg.control[6],
                     view_out_reg.control[7],
                     rdata_reg};

endmodule

/* rtl/core/cpu_bus_decode_ppu_registers_core.sv */
// Top level of the CPU bus port for the picture processor registers, RAM and ROM.
`timescale 1ns / 1ps

// Usage:
//   The slave channel takes one CPU bus word per handshake: s_tuser carries the
//   access kind (read, write, program ROM load), s_tdata the address, the write
//   byte and the three renderer status flags. The master channel returns one
//   word per accepted input: the read byte (zero for non-reads) and the control,
//   mask and scroll values as they stand after that access.
// Pipeline and throughput:
//   m_tvalid rises once an accepted word has passed the input register, the
//   decode and memory access (registered read data) and the result register.
//   One word per cycle is sustained while m_tready keeps the results moving;
//   every access goes through the same single decode pass.
// Stall:
//   The whole pipeline moves on one enable. While a result waits and m_tready
//   is low, hold every stage and drop s_tready; s_tready rises again in the
//   cycle the waiting result is taken.
// Reset:
//   aresetn (synchronous, active low) empties the pipeline and clears the
//   pointers, latch, control, mask and scroll; the first-write toggle is set.
//   Memory contents are left as they are and count as unknown until written.
module cpu_bus_decode_ppu_registers_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] address, [23:16] write_data, [24] vblank_flag,
    // [25] sprite_zero_hit, [26] sprite_overflow_flag, [31:27] zero
    input  logic [cbdppu_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] func
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] read_data, [8] nmi_enable, [9] master_mode, [10] sprite_large,
    // [11] bg_table_high, [12] sprite_table_high, [14:13] nametable_select,
    // [15] step_is_32, [16] show_bg, [17] show_sprites,
    // [25:18] hscroll, [33:26] vscroll, [39:34] zero
    output logic [cbdppu_pkg::M_TDATA_W-1:0]    m_tdata
);

    logic                  adv;
    logic                  in_valid_reg, in_valid_next;
    logic                  mid_valid_reg, mid_valid_next;
    logic                  out_valid_reg, out_valid_next;
    cbdppu_pkg::item_t     item_reg;
    cbdppu_pkg::mem_cmd_t  mem_cmd;
    cbdppu_pkg::rd_sel_t   rd_sel;
    cbdppu_pkg::view_t     view_next;
    logic [7:0]            ram_rdata, rom_rdata, oam_rdata, vram_rdata;

    // Advance all stages when the result register is free or being taken
    assign adv      = ~out_valid_reg | m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_valid_reg;

    assign in_valid_next  = adv ? s_tvalid      : in_valid_reg;
    assign mid_valid_next = adv ? in_valid_reg  : mid_valid_reg;
    assign out_valid_next = adv ? mid_valid_reg : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register: unpack the word into its fields
    always_ff @(posedge aclk) begin
        if (adv) begin
            item_reg.func                 <= s_tuser;
            item_reg.address              <= s_tdata[15:0];
            item_reg.write_data           <= s_tdata[23:16];
            item_reg.vblank_flag          <= s_tdata[24];
            item_reg.sprite_zero_hit      <= s_tdata[25];
            item_reg.sprite_overflow_flag <= s_tdata[26];
        end
    end

    // Decode and register state; commits only for a valid word that advances
    cbdppu_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (adv & in_valid_reg),
        .item      (item_reg),
        .mem_cmd   (mem_cmd),
        .rd_sel    (rd_sel),
        .view_next (view_next)
    );

    cbdppu_mem u_mem (
        .aclk       (aclk),
        .rd_en      (adv),
        .mem_cmd    (mem_cmd),
        .ram_rdata  (ram_rdata),
        .rom_rdata  (rom_rdata),
        .oam_rdata  (oam_rdata),
        .vram_rdata (vram_rdata)
    );

    cbdppu_out u_out (
        .aclk       (aclk),
        .adv        (adv),
        .rd_sel     (rd_sel),
        .view_next  (view_next),
        .ram_rdata  (ram_rdata),
        .rom_rdata  (rom_rdata),
        .oam_rdata  (oam_rdata),
        .vram_rdata (vram_rdata),
        .m_word     (m_tdata)
    );

endmodule

/* rtl/core/cbdppu_checker.sv */
// Port-level checks for the picture processor register port, bound to the top level.
`timescale 1ns / 1ps

module cbdppu_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [cbdppu_pkg::M_TDATA_W-1:0]  m_tdata
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Input is taken exactly when the result side can move
    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow result stall");

    // An accepted word reaches m_tvalid when m_tready stays high behind it
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("result missing three cycles after accept");

endmodule

bind cpu_bus_decode_ppu_registers_core cbdppu_checker u_cbdppu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/tb.sv */
// Self-checking stream testbench for the picture processor register port.
`timescale 1ns / 1ps

module tb;
    import cbdppu_pkg::*;

    // Bus access kind that does nothing; the package enum stops at ROM load
    localparam logic [1:0]  FUNC_NONE   = 2'd3;
    // Start of the register window and of the program ROM on the CPU bus
    localparam logic [15:0] IO_BASE     = 16'h2000;
    localparam logic [15:0] ROM_BASE    = 16'h8000;
    // Upper end of the mirrored work RAM and of the unused I/O area
    localparam logic [15:0] RAM_TOP     = 16'h1FFF;
    localparam logic [15:0] IO_TOP      = 16'h7FFF;
    localparam int          HOLD_CYCLES = 60;
    localparam int          PHASE_WORDS = 100;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          CYCLE_LIMIT = 200000;

    // Result word as it sits on m_tdata, highest field first
    typedef struct packed {
        logic [5:0] pad;
        logic [7:0] vscroll;
        logic [7:0] hscroll;
        logic       show_sprites;
        logic       show_bg;
        logic       step_is_32;
        logic [1:0] nametable_select;
        logic       sprite_table_high;
        logic       bg_table_high;
        logic       sprite_large;
        logic       master_mode;
        logic       nmi_enable;
        logic [7:0] read_data;
    } bus_result_t;

    // One row of the opening sequence; typed rows carry a hand-written result
    typedef struct {
        item_t       word;
        bit          typed;
        bus_result_t want;
    } step_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [1:0]           s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    cpu_bus_decode_ppu_registers_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the block: memories with a written flag per entry, so that
    // the stimulus never reads an entry that was never written.
    // ------------------------------------------------------------------
    logic [7:0]         ram_q  [RAM_BYTES];
    logic [7:0]         rom_q  [ROM_BYTES];
    logic [7:0]         oam_q  [OAM_BYTES];
    logic [7:0]         vram_q [VRAM_BYTES];
    bit                 ram_ok  [RAM_BYTES];
    bit                 rom_ok  [ROM_BYTES];
    bit                 oam_ok  [OAM_BYTES];
    bit                 vram_ok [VRAM_BYTES];
    logic [OAM_AW-1:0]  oam_ptr     = '0;
    logic [VRAM_AW-1:0] vram_ptr    = '0;
    logic [7:0]         addr_latch  = '0;
    logic               first_write = 1'b1;
    view_t              regs        = '0;

    bus_result_t replies_due [$];   // results still owed by the block, oldest first
    item_t       plan_q [$];        // planned random words not yet offered
    step_row_t   opening_rows [$];

    int faults       = 0;
    int checked      = 0;
    int stall_pct    = 0;
    int hold_trigger = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int held_cycles  = 0;
    int cycle_count  = 0;
    int n_read = 0, n_write = 0, n_load = 0, n_none = 0, n_video_rd = 0, n_sprite_rd = 0;

    // Build a result from a read byte and the register view
    function automatic bus_result_t compose(logic [7:0] rd, view_t v);
        bus_result_t r;
        r                    = '0;
        r.read_data          = rd;
        r.nmi_enable         = v.control[7];
        r.master_mode        = v.control[6];
        r.sprite_large       = v.control[5];
        r.bg_table_high      = v.control[4];
        r.sprite_table_high  = v.control[3];
        r.step_is_32         = v.control[2];
        r.nametable_select   = v.control[1:0];
        r.show_bg            = v.mask[0];
        r.show_sprites       = v.mask[1];
        r.hscroll            = v.scroll[7:0];
        r.vscroll            = v.scroll[15:8];
        return r;
    endfunction

    // Apply one bus access to the shadow state and return the result it gives
    task automatic run_bus_access(input item_t w, output bus_result_t r);
        logic [7:0] rd;
        logic [7:0] d;
        rd = 8'h00;
        d  = w.write_data;
        case (w.func)
            FUNC_READ: begin
                if (w.address < IO_BASE) begin
                    rd = ram_q[w.address[RAM_AW-1:0]];
                end else if (w.address >= ROM_BASE) begin
                    rd = rom_q[w.address[ROM_AW-1:0]];
                end else if (w.address == ADDR_STATUS) begin
                    // status read also rearms the two-write toggle
                    rd = {w.vblank_flag, w.sprite_zero_hit, w.sprite_overflow_flag, 5'b0};
                    first_write = 1'b1;
                end else if (w.address == ADDR_OAM_DATA) begin
                    rd = oam_q[oam_ptr];
                end else if (w.address == ADDR_VDATA) begin
                    rd = vram_q[vram_ptr];
                    vram_ptr += regs.control[2] ? 14'd32 : 14'd1;
                end
            end
            FUNC_WRITE: begin
                if (w.address < IO_BASE) begin
                    ram_q[w.address[RAM_AW-1:0]]  = d;
                    ram_ok[w.address[RAM_AW-1:0]] = 1'b1;
                end else begin
                    case (w.address)
                        ADDR_CTRL:     regs.control = d;
                        ADDR_MASK:     regs.mask = {d[4], d[3]};
                        ADDR_OAM_ADDR: oam_ptr = d;
                        ADDR_OAM_DATA: begin
                            oam_q[oam_ptr]  = d;
                            oam_ok[oam_ptr] = 1'b1;
                            oam_ptr++;
                        end
                        ADDR_SCROLL: begin
                            if (first_write) regs.scroll[7:0] = d;
                            else regs.scroll[15:8] = d;
                            first_write = !first_write;
                        end
                        ADDR_VADDR: begin
                            if (first_write) addr_latch = d;
                            else vram_ptr = {addr_latch[5:0], d};
                            first_write = !first_write;
                        end
                        ADDR_VDATA: begin
                            vram_q[vram_ptr]  = d;
                            vram_ok[vram_ptr] = 1'b1;
                            vram_ptr += regs.control[2] ? 14'd32 : 14'd1;
                        end
                        default: ;
                    endcase
                end
            end
            FUNC_LOAD: begin
                rom_q[w.address[ROM_AW-1:0]]  = d;
                rom_ok[w.address[ROM_AW-1:0]] = 1'b1;
            end
            default: ;
        endcase
        r = compose(rd, regs);
    endtask

    // A read is legal only where the entry it reaches has been written
    function automatic bit readable(item_t w);
        if (w.address < IO_BASE) return ram_ok[w.address[RAM_AW-1:0]];
        if (w.address >= ROM_BASE) return rom_ok[w.address[ROM_AW-1:0]];
        if (w.address == ADDR_OAM_DATA) return oam_ok[oam_ptr];
        if (w.address == ADDR_VDATA) return vram_ok[vram_ptr];
        return 1'b1;
    endfunction

    // Bus word with random renderer flags
    function automatic item_t mk(logic [1:0] f, logic [15:0] a, logic [7:0] d);
        item_t w;
        w.func                 = f;
        w.address              = a;
        w.write_data           = d;
        w.vblank_flag          = 1'($urandom_range(1));
        w.sprite_zero_hit      = 1'($urandom_range(1));
        w.sprite_overflow_flag = 1'($urandom_range(1));
        return w;
    endfunction

    task automatic add_row(input logic [1:0] f, input logic [15:0] a, input logic [7:0] d,
                           input logic [2:0] flags, input bit typed,
                           input logic [7:0] rd, input logic [7:0] ctl);
        step_row_t row;
        row.word                      = mk(f, a, d);
        row.word.vblank_flag          = flags[2];
        row.word.sprite_zero_hit      = flags[1];
        row.word.sprite_overflow_flag = flags[0];
        row.typed                     = typed;
        row.want = compose(rd, '{control: ctl, mask: 2'b00, scroll: 16'h0000});
        opening_rows.push_back(row);
    endtask

    // Queue one random access sequence. Most are well-formed register
    // sequences with random content so that read-back reaches written data;
    // the rest are broken sequences and plain noise.
    task automatic plan_sequence();
        int          kind;
        int          n;
        logic [15:0] a;
        logic [7:0]  p;
        logic [15:0] spots [$];
        kind = $urandom_range(99);
        n    = $urandom_range(1, 4);
        if (kind < 14) begin
            // work RAM: write, then read back through a random mirror
            repeat (n) begin
                a = 16'($urandom_range(RAM_TOP));
                spots.push_back(a);
                plan_q.push_back(mk(FUNC_WRITE, a, 8'($urandom)));
            end
            foreach (spots[i]) begin
                a        = spots[i];
                a[12:11] = 2'($urandom_range(3));
                plan_q.push_back(mk(FUNC_READ, a, 8'($urandom)));
            end
        end else if (kind < 28) begin
            // program ROM: load anywhere on the bus, read in the ROM window
            repeat (n) begin
                a = 16'($urandom);
                spots.push_back(a);
                plan_q.push_back(mk(FUNC_LOAD, a, 8'($urandom)));
            end
            foreach (spots[i])
                plan_q.push_back(mk(FUNC_READ, ROM_BASE | spots[i], 8'($urandom)));
        end else if (kind < 42) begin
            // sprite memory: fill from a random pointer, point back, read
            p = 8'($urandom);
            plan_q.push_back(mk(FUNC_WRITE, ADDR_OAM_ADDR, p));
            repeat (n) plan_q.push_back(mk(FUNC_WRITE, ADDR_OAM_DATA, 8'($urandom)));
            plan_q.push_back(mk(FUNC_WRITE, ADDR_OAM_ADDR, 8'(p + $urandom_range(n - 1))));
            repeat ($urandom_range(1, 2))
                plan_q.push_back(mk(FUNC_READ, ADDR_OAM_DATA, 8'($urandom)));
        end else if (kind < 60) begin
            // video memory: set address, write a run, set it again, read the run
            p = 8'($urandom);
            a = 16'($urandom);
            plan_q.push_back(mk(FUNC_READ, ADDR_STATUS, 8'($urandom)));
            plan_q.push_back(mk(FUNC_WRITE, ADDR_VADDR, p));
            plan_q.push_back(mk(FUNC_WRITE, ADDR_VADDR, a[7:0]));
            repeat (n) plan_q.push_back(mk(FUNC_WRITE, ADDR_VDATA, 8'($urandom)));
            plan_q.push_back(mk(FUNC_WRITE, ADDR_VADDR, p));
            plan_q.push_back(mk(FUNC_WRITE, ADDR_VADDR, a[7:0]));
            repeat (n) plan_q.push_back(mk(FUNC_READ, ADDR_VDATA, 8'($urandom)));
        end else if (kind < 70) begin
            plan_q.push_back(mk(FUNC_READ, ADDR_STATUS, 8'($urandom)));
            plan_q.push_back(mk(FUNC_WRITE, ADDR_SCROLL, 8'($urandom)));
            plan_q.push_back(mk(FUNC_WRITE, ADDR_SCROLL, 8'($urandom)));
        end else if (kind < 80) begin
            plan_q.push_back(mk(FUNC_WRITE, ADDR_CTRL, 8'($urandom)));
            plan_q.push_back(mk(FUNC_WRITE, ADDR_MASK, 8'($urandom)));
        end else if (kind < 90) begin
            // broken sequences: lone toggle writes, dead register reads, I/O holes
            case ($urandom_range(3))
                0: plan_q.push_back(mk(FUNC_WRITE, ADDR_SCROLL, 8'($urandom)));
                1: plan_q.push_back(mk(FUNC_WRITE, ADDR_VADDR, 8'($urandom)));
                2: plan_q.push_back(mk(FUNC_READ, 16'(ADDR_CTRL + $urandom_range(7)),
                                       8'($urandom)));
                default: plan_q.push_back(mk(2'($urandom_range(1)),
                                             16'($urandom_range(IO_TOP, ADDR_VDATA + 1)),
                                             8'($urandom)));
            endcase
        end else begin
            plan_q.push_back(mk(2'($urandom_range(FUNC_NONE)), 16'($urandom),
                                8'($urandom)));
        end
    endtask

    // Offer one word and hold it until the block takes it; predict at that edge
    task automatic offer(input item_t w, input bit typed, input bus_result_t fixed);
        bus_result_t r;
        s_tvalid <= 1'b1;
        s_tuser  <= w.func;
        s_tdata  <= {5'b0, w.sprite_overflow_flag, w.sprite_zero_hit, w.vblank_flag,
                     w.write_data, w.address};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        run_bus_access(w, r);
        replies_due.push_back(typed ? fixed : r);
        case (w.func)
            FUNC_READ: begin
                n_read++;
                if (w.address == ADDR_VDATA) n_video_rd++;
                if (w.address == ADDR_OAM_DATA) n_sprite_rd++;
            end
            FUNC_WRITE: n_write++;
            FUNC_LOAD:  n_load++;
            default:    n_none++;
        endcase
    endtask

    // Drop valid for a random number of cycles, pct in a hundred per cycle
    task automatic idle_gap(input int pct);
        while ($urandom_range(99) < pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            faults++;
            if (faults <= 10)
                $display("result %0d: %s expected %0h, got %0h", checked, name, want, got);
        end
    endtask

    // Receiver: random stalls at the current rate, plus a long hold-off on
    // request, counted here, that lets the pipeline fill and drop s_tready.
    always @(posedge aclk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare every taken result, field by field, with the oldest one owed
    always @(posedge aclk) begin : check_results
        bus_result_t got;
        bus_result_t want;
        if (aresetn && s_tvalid && !s_tready) held_cycles++;
        if (aresetn && m_tvalid && m_tready) begin
            got = bus_result_t'(m_tdata);
            if (replies_due.size() == 0) begin
                faults++;
                if (faults <= 10) $display("result word %0h with none owed", m_tdata);
            end else begin
                want = replies_due.pop_front();
                check_field("read_data", want.read_data, got.read_data);
                check_field("nmi_enable", 8'(want.nmi_enable), 8'(got.nmi_enable));
                check_field("master_mode", 8'(want.master_mode), 8'(got.master_mode));
                check_field("sprite_large", 8'(want.sprite_large), 8'(got.sprite_large));
                check_field("bg_table_high", 8'(want.bg_table_high),
                            8'(got.bg_table_high));
                check_field("sprite_table_high", 8'(want.sprite_table_high),
                            8'(got.sprite_table_high));
                check_field("nametable_select", 8'(want.nametable_select),
                            8'(got.nametable_select));
                check_field("step_is_32", 8'(want.step_is_32), 8'(got.step_is_32));
                check_field("show_bg", 8'(want.show_bg), 8'(got.show_bg));
                check_field("show_sprites", 8'(want.show_sprites), 8'(got.show_sprites));
                check_field("hscroll", want.hscroll, got.hscroll);
                check_field("vscroll", want.vscroll, got.vscroll);
            end
            checked++;
        end
    end

    // Watchdog: end a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results owed", cycle_count,
                     replies_due.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        item_t w;
        int    ph;
        int    sent;
        int    send_pct  [4];
        int    stall_set [4];
        // phases: no idling, sender idle, receiver stalling, both
        send_pct  = '{0, 74, 0, 37};
        stall_set = '{0, 0, 74, 37};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Opening sequence. Typed rows start from reset state and are read off
        // directly; the rest go through the shadow model.
        add_row(FUNC_READ,  ADDR_CTRL,   8'h00, 3'b000, 1'b1, 8'h00, 8'h00);
        add_row(FUNC_READ,  ADDR_STATUS, 8'h00, 3'b111, 1'b1, 8'hE0, 8'h00);
        add_row(FUNC_WRITE, 16'h0000,    8'hFF, 3'b000, 1'b1, 8'h00, 8'h00);
        add_row(FUNC_READ,  16'h1800,    8'h00, 3'b000, 1'b1, 8'hFF, 8'h00);  // top mirror
        add_row(FUNC_WRITE, RAM_TOP,     8'h00, 3'b111, 1'b1, 8'h00, 8'h00);
        add_row(FUNC_READ,  16'h07FF,    8'hFF, 3'b000, 1'b1, 8'h00, 8'h00);
        add_row(FUNC_LOAD,  16'hFFFF,    8'hA5, 3'b000, 1'b1, 8'h00, 8'h00);
        add_row(FUNC_WRITE, 16'hFFFF,    8'h11, 3'b000, 1'b1, 8'h00, 8'h00);  // ROM: ignored
        add_row(FUNC_READ,  16'hFFFF,    8'h00, 3'b000, 1'b1, 8'hA5, 8'h00);
        add_row(FUNC_NONE,  16'h0000,    8'h12, 3'b111, 1'b1, 8'h00, 8'h00);  // no-op kind
        add_row(FUNC_READ,  16'h0000,    8'h00, 3'b000, 1'b1, 8'hFF, 8'h00);
        add_row(FUNC_WRITE, ADDR_STATUS, 8'h55, 3'b000, 1'b1, 8'h00, 8'h00);  // ignored
        add_row(FUNC_READ,  IO_TOP,      8'h00, 3'b111, 1'b1, 8'h00, 8'h00);  // I/O hole
        add_row(FUNC_WRITE, ADDR_CTRL,   8'hFF, 3'b000, 1'b1, 8'h00, 8'hFF);
        add_row(FUNC_WRITE, ADDR_MASK,   8'hFF, 3'b000, 1'b0, 8'h00, 8'h00);
        // sprite pointer wraps past the top entry
        add_row(FUNC_WRITE, ADDR_OAM_ADDR, 8'hFF, 3'b000, 1'b0, 8'h00, 8'h00);
        add_row(FUNC_WRITE, ADDR_OAM_DATA, 8'h5A, 3'b000, 1'b0, 8'h00, 8'h00);
        add_row(FUNC_WRITE, ADDR_OAM_ADDR, 8'hFF, 3'b000, 1'b0, 8'h00, 8'h00);
        add_row(FUNC_READ,  ADDR_OAM_DATA, 8'h00, 3'b000, 1'b0, 8'h00, 8'h00);
        add_row(FUNC_WRITE, ADDR_SCROLL, 8'hFF, 3'b000, 1'b0, 8'h00, 8'h00);
        add_row(FUNC_WRITE, ADDR_SCROLL, 8'h00, 3'b000, 1'b0, 8'h00, 8'h00);
        // video pointer at its top, step of 32 wraps to the bottom
        add_row(FUNC_WRITE, ADDR_VADDR,  8'hFF, 3'b000, 1'b0, 8'h00, 8'h00);
        add_row(FUNC_WRITE, ADDR_VADDR,  8'hFF, 3'b000, 1'b0, 8'h00, 8'h00);
        add_row(FUNC_WRITE, ADDR_VDATA,  8'h77, 3'b000, 1'b0, 8'h00, 8'h00);
        add_row(FUNC_WRITE, ADDR_VADDR,  8'h3F, 3'b000, 1'b0, 8'h00, 8'h00);
        add_row(FUNC_WRITE, ADDR_VADDR,  8'hFF, 3'b000, 1'b0, 8'h00, 8'h00);
        add_row(FUNC_READ,  ADDR_VDATA,  8'h00, 3'b000, 1'b0, 8'h00, 8'h00);

        foreach (opening_rows[i])
            offer(opening_rows[i].word, opening_rows[i].typed, opening_rows[i].want);

        for (ph = 0; ph < 4; ph++) begin
            stall_pct <= stall_set[ph];
            // back-to-back words into a held receiver fill the pipeline
            if (ph == 0) hold_trigger <= hold_trigger + 1;
            sent = 0;
            while (sent < PHASE_WORDS) begin
                if (plan_q.size() == 0) plan_sequence();
                w = plan_q.pop_front();
                // turn a read of never-written data into a write at the same place
                if (w.func == FUNC_READ && !readable(w)) w.func = FUNC_WRITE;
                idle_gap(send_pct[ph]);
                offer(w, 1'b0, '0);
                sent++;
            end
        end

        s_tvalid  <= 1'b0;
        stall_pct <= 0;
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        faults += replies_due.size();

        $display("covered %0d words: %0d reads (%0d video, %0d sprite), %0d writes,",
                 n_read + n_write + n_load + n_none, n_read, n_video_rd, n_sprite_rd, n_write);
        $display("  %0d ROM loads, %0d no-ops; %0d results checked, input stalled %0d cycles",
                 n_load, n_none, checked, held_cycles);
        if (faults == 0) begin
            $display("tb OK");
        end else begin
            $display("%0d failures", faults);
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/cbdppu_pkg.sv
rtl/core/cbdppu_regs.sv
rtl/core/cbdppu_mem.sv
rtl/core/cbdppu_out.sv
rtl/core/cpu_bus_decode_ppu_registers_core.sv
rtl/core/cbdppu_checker.sv
tb/tb.sv
